>>> src/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 engine.
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] hash_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic restart;
  } core_ctl_t;

  localparam hash_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 80;
  localparam int unsigned WORDS_PER_BLOCK = 16;

  function automatic word_t round_k(input logic [6:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

>>> src/sha1_buf.sv
// Block buffer: sixteen 32-bit words, one write port, one registered read port.
module sha1_buf (
  input  logic                clk,
  input  logic                we,
  input  logic [3:0]          waddr,
  input  sha1_pkg::word_t     wdata,
  input  logic [3:0]          raddr,
  output sha1_pkg::word_t     rdata
);
  import sha1_pkg::*;

  word_t mem [WORDS_PER_BLOCK];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sha1_core.sv
// Compression core: one SHA-1 round per cycle over the buffered block, holds h0..h4.
module sha1_core (
  input  logic                clk,
  input  logic                rst,
  input  sha1_pkg::core_ctl_t ctl,
  input  sha1_pkg::word_t     rd_data,
  output logic [3:0]          rd_addr,
  output logic                done,
  output sha1_pkg::hash_t     digest
);
  import sha1_pkg::*;

  logic       prime;
  logic       run;
  logic       fin;
  logic [6:0] rnd;
  word_t      a, b, c, d, e;
  word_t      win [WORDS_PER_BLOCK];
  word_t      mix;
  word_t      w;
  word_t      t;
  hash_t      h;

  assign mix     = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w       = (rnd < 7'd16) ? rd_data : {mix[30:0], mix[31]};
  assign t       = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + w;
  assign rd_addr = prime ? 4'd0 : rnd[3:0] + 4'd1;
  assign done    = fin;
  assign digest  = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= 1'b0;
      run   <= 1'b0;
      fin   <= 1'b0;
      rnd   <= '0;
      h     <= H_INIT;
    end else begin
      fin <= 1'b0;
      if (ctl.restart) begin
        h <= H_INIT;
      end
      if (ctl.start) begin
        prime <= 1'b1;
        rnd   <= '0;
      end
      if (prime) begin
        prime <= 1'b0;
        run   <= 1'b1;
      end
      if (run) begin
        rnd <= rnd + 7'd1;
        if (rnd == 7'(ROUNDS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (run) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    if (run) begin
      for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[WORDS_PER_BLOCK - 1] <= w;
    end
  end

endmodule

>>> src/sha1_hash_engine_unit.sv
// SHA-1 engine top level: byte intake, padding sequencer and digest output.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+-----------------------
//   in      | data_byte, byte_present, end_of_message   | in_valid / in_ready
//   out     | digest_word, word_index, last_word        | out_valid / out_ready
//
// Bytes are taken in the idle state; a byte that fills the 64-byte block holds in_ready low
// through the read prime, 80 rounds on the block buffer and the chaining add.
// End of message writes the remaining pad words of the block, one a cycle, then
// compresses; with 56 or more bytes buffered a second 16-word block follows.
// The five digest words then go out one per accepted request; out stalls hold.
// rst is synchronous, active high, and restores the initial chaining values.
module sha1_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill;
  logic [5:0]  fill_new;
  logic [63:0] len;
  logic [3:0]  widx;
  logic [2:0]  oidx;
  logic        fin_pend;
  logic        padded;
  logic        last_blk;
  logic        spill;
  word_t       acc;
  word_t       acc_merged;
  word_t       pad_word;
  word_t       part_word;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  word_t       mem_wdata;
  logic [3:0]  mem_raddr;
  word_t       mem_rdata;
  core_ctl_t   ctl;
  logic        done;
  hash_t       digest;
  logic        accept;

  sha1_buf u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sha1_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (mem_rdata),
    .rd_addr (mem_raddr),
    .done    (done),
    .digest  (digest)
  );

  assign accept   = in_valid && in_ready;
  assign fill_new = byte_present ? fill + 6'd1 : fill;
  assign spill    = !padded && (fill[5:3] == 3'b111);

  always_comb begin
    acc_merged = acc;
    part_word  = '0;
    for (int l = 0; l < 4; l++) begin
      if (fill[1:0] == 2'(l)) begin
        acc_merged[31 - 8 * l -: 8] = data_byte;
        part_word[31 - 8 * l -: 8]  = PAD_BYTE;
      end else if (fill[1:0] > 2'(l)) begin
        part_word[31 - 8 * l -: 8]  = acc[31 - 8 * l -: 8];
      end
    end
  end

  always_comb begin
    pad_word = '0;
    if (!padded && widx == fill[5:2]) begin
      pad_word = part_word;
    end else if (!spill && widx == 4'd14) begin
      pad_word = len[63:32];
    end else if (!spill && widx == 4'd15) begin
      pad_word = len[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (byte_present && fill == 6'd63) begin
            state_next = ST_COMP;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (widx == 4'd15) begin
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        if (done) begin
          if (last_blk) begin
            state_next = ST_OUT;
          end else if (fin_pend) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_ready && oidx == 3'd4) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    out_valid   = (state == ST_OUT);
    mem_we      = 1'b0;
    mem_waddr   = widx;
    mem_wdata   = pad_word;
    ctl.start   = (state_next == ST_COMP) && (state != ST_COMP);
    ctl.restart = (state == ST_OUT) && out_ready && (oidx == 3'd4);
    case (state)
      ST_IDLE: begin
        mem_we    = in_valid && byte_present && (fill[1:0] == 2'd3);
        mem_waddr = fill[5:2];
        mem_wdata = acc_merged;
      end
      ST_PAD: begin
        mem_we = 1'b1;
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign digest_word = digest[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      len      <= '0;
      widx     <= '0;
      oidx     <= '0;
      fin_pend <= 1'b0;
      padded   <= 1'b0;
      last_blk <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (byte_present) begin
              fill <= fill + 6'd1;
              len  <= len + 64'd8;
            end
            if (byte_present && fill == 6'd63) begin
              fin_pend <= end_of_message;
              last_blk <= 1'b0;
            end else if (end_of_message) begin
              widx <= fill_new[5:2];
            end
          end
        end
        ST_PAD: begin
          widx <= widx + 4'd1;
          if (widx == 4'd15) begin
            if (spill) begin
              fin_pend <= 1'b1;
              padded   <= 1'b1;
              last_blk <= 1'b0;
            end else begin
              last_blk <= 1'b1;
            end
          end
        end
        ST_COMP: begin
          oidx <= '0;
          if (done && !last_blk && fin_pend) begin
            fin_pend <= 1'b0;
            widx     <= '0;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd4) begin
              oidx     <= '0;
              fill     <= '0;
              len      <= '0;
              fin_pend <= 1'b0;
              padded   <= 1'b0;
              last_blk <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_present) begin
      acc <= acc_merged;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output active together");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_index <= 3'd4))
    else $error("digest word index out of range");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> in_ready)
    else $error("engine not idle after last digest word");

  a_pad_ends_in_comp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD && widx == 4'd15) |=> (state == ST_COMP))
    else $error("pad block not handed to compression");

endmodule
